[design/md5sw_pkg.sv]
// ----------------------------------------------------------------------------
// md5sw_pkg
// Shared types, MD5 round constants and the single-round function.
// ----------------------------------------------------------------------------
package md5sw_pkg;

  // Per-word sideband that travels with each window
  typedef struct packed {
    logic        first;   // word opened a new stream
    logic        full;    // window holds a complete set of bytes
    logic [31:0] start;   // stream offset of the window's first byte
  } meta_t;

  // MD5 chaining state
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  // Configuration register indexes
  localparam logic REG_TGT_LO = 1'b0;
  localparam logic REG_TGT_HI = 1'b1;

  localparam abcd_t MD5_IV = '{a: 32'h67452301, b: 32'hefcdab89,
                               c: 32'h98badcfe, d: 32'h10325476};

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by round i
  function automatic logic [3:0] md5_g(input int unsigned i);
    int unsigned g;
    unique case (i / 16)
      0:       g = i;
      1:       g = 5 * i + 1;
      2:       g = 3 * i + 5;
      default: g = 7 * i;
    endcase
    return g[3:0];
  endfunction

  // One MD5 round
  function automatic abcd_t md5_round(input abcd_t s, input logic [31:0] mw,
                                      input logic [31:0] k, input logic [4:0] rot,
                                      input logic [1:0] grp);
    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] r;
    abcd_t       n;
    unique case (grp)
      2'd0:    f = (s.b & s.c) | (~s.b & s.d);
      2'd1:    f = (s.d & s.b) | (~s.d & s.c);
      2'd2:    f = s.b ^ s.c ^ s.d;
      default: f = s.c ^ (s.b | ~s.d);
    endcase
    t   = f + s.a + k + mw;
    r   = (t << rot) | (t >> (6'd32 - {1'b0, rot}));
    n.a = s.d;
    n.d = s.c;
    n.c = s.b;
    n.b = s.b + r;
    return n;
  endfunction

endpackage

[design/md5sw_if.sv]
// ----------------------------------------------------------------------------
// md5sw_if
// Valid/ready channels for text bytes and match results.
// ----------------------------------------------------------------------------
interface md5sw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_of_stream;
  modport source(output valid, output text_byte, output first_of_stream, input ready);
  modport sink(input valid, input text_byte, input first_of_stream, output ready);
endinterface

interface md5sw_out_if;
  logic        valid;
  logic        ready;
  logic        window_hashed;
  logic        matched;
  logic [31:0] window_start;
  logic [31:0] windows_hashed;
  modport source(output valid, output window_hashed, output matched,
                 output window_start, output windows_hashed, input ready);
  modport sink(input valid, input window_hashed, input matched,
               input window_start, input windows_hashed, output ready);
endinterface

[design/md5_sliding_window_match_unit.sv]
// ----------------------------------------------------------------------------
// md5_sliding_window_match_unit
// MD5 sliding-window search of a byte stream for a target digest.
// ----------------------------------------------------------------------------
// Every accepted byte gives one result word. Throughput is one byte per clock
// while the result channel is not back-pressured. The window of each byte is
// written to the queue at acceptance, then passes the 64-stage MD5 round
// pipeline and the output register. The found flag and hash count are resolved
// in order at the pipeline exit, so hashing never throttles the input. Program
// the target digest over APB (low half at 0x0, high half at 0x8) while idle.
module md5_sliding_window_match_unit #(
  parameter int unsigned WINDOW_LEN   = 19,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5sw_in_if.sink    text_i,
  md5sw_out_if.source result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import md5sw_pkg::*;

  localparam int unsigned ENTRY_W = $bits(meta_t) + WINDOW_LEN * 8;

  // Config registers
  logic [63:0] tgt_lo_q, tgt_hi_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[3] == REG_TGT_HI) ? tgt_hi_q : tgt_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lo_q <= '0;
      tgt_hi_q <= '0;
    end else if (wr_en) begin
      if (paddr[3] == REG_TGT_LO) tgt_lo_q <= pwdata;
      if (paddr[3] == REG_TGT_HI) tgt_hi_q <= pwdata;
    end
  end

  // Front end
  logic                    push, q_full, q_valid, q_pop;
  logic [WINDOW_LEN*8-1:0] f_win, q_win;
  meta_t                   f_meta, q_meta;

  md5sw_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .q_full_i(q_full),
    .push_o  (push),
    .win_o   (f_win),
    .meta_o  (f_meta)
  );

  md5sw_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_meta, f_win}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o ({q_meta, q_win})
  );

  // Hash back end
  md5sw_back #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_win_i  (q_win),
    .q_meta_i (q_meta),
    .q_pop_o  (q_pop),
    .tgt_lo_i (tgt_lo_q),
    .tgt_hi_i (tgt_hi_q),
    .result_o (result_o)
  );

  // A match is always a hashed window
  a_match_hashed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.matched |-> result_o.window_hashed)
    else $error("match reported without a hash");

  // A hashed window is counted
  a_hash_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.window_hashed |-> result_o.windows_hashed != 32'd0)
    else $error("hashed window not counted");

  // Queue is never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue overflow");

endmodule

[design/md5sw_front.sv]
// ----------------------------------------------------------------------------
// md5sw_front
// Accepts text bytes, shifts the window, tracks fill and stream offset.
// ----------------------------------------------------------------------------
module md5sw_front #(
  parameter int unsigned WINDOW_LEN   = 19,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  md5sw_in_if.sink                text_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output logic [WINDOW_LEN*8-1:0] win_o,
  output md5sw_pkg::meta_t        meta_o
);
  import md5sw_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);

  logic [7:0]              win_q [WINDOW_LEN];
  logic [7:0]              win_d [WINDOW_LEN];
  logic [FILL_W-1:0]       fill_q, fill_d, fill_base;
  logic [OFFSET_WIDTH-1:0] off_q, off_base, start;

  assign text_i.ready = !q_full_i;
  assign push_o       = text_i.valid && !q_full_i;

  // New stream restarts fill and offset
  assign fill_base = text_i.first_of_stream ? '0 : fill_q;
  assign off_base  = text_i.first_of_stream ? '0 : off_q;
  assign fill_d    = (fill_base < FILL_W'(WINDOW_LEN)) ? fill_base + 1'b1 : fill_base;
  assign start     = off_base - OFFSET_WIDTH'(WINDOW_LEN - 1);

  // Window shift: oldest byte at index 0
  always_comb begin
    for (int unsigned i = 0; i + 1 < WINDOW_LEN; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[WINDOW_LEN-1] = text_i.text_byte;
  end

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_flat
    assign win_o[8*i +: 8] = win_d[i];
  end

  assign meta_o.first = text_i.first_of_stream;
  assign meta_o.full  = (fill_d == FILL_W'(WINDOW_LEN));
  assign meta_o.start = 32'(start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      off_q  <= '0;
    end else if (push_o) begin
      fill_q <= fill_d;
      off_q  <= off_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      win_q <= win_d;
    end
  end

endmodule

[design/md5sw_queue.sv]
// ----------------------------------------------------------------------------
// md5sw_queue
// Two-entry queue between the front end and the hash pipeline.
// ----------------------------------------------------------------------------
module md5sw_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import md5sw_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

[design/md5sw_back.sv]
// ----------------------------------------------------------------------------
// md5sw_back
// 64-stage MD5 pipeline, digest compare and in-order match resolution.
// ----------------------------------------------------------------------------
module md5sw_back #(
  parameter int unsigned WINDOW_LEN = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  logic [WINDOW_LEN*8-1:0] q_win_i,
  input  md5sw_pkg::meta_t        q_meta_i,
  output logic                    q_pop_o,
  input  logic [63:0]             tgt_lo_i,
  input  logic [63:0]             tgt_hi_i,
  md5sw_out_if.source             result_o
);
  import md5sw_pkg::*;

  localparam int unsigned MSG_BITS = WINDOW_LEN * 8;

  logic [7:0]   blk [64];
  logic [511:0] m0;
  logic         en;
  logic         v_q  [64];
  abcd_t        st_q [64];
  logic [511:0] m_q  [64];
  meta_t        mt_q [64];

  // Pipeline advances when the output register is free or being taken
  assign en      = !result_o.valid || result_o.ready;
  assign q_pop_o = en && q_valid_i;

  // Padded single-block message
  for (genvar k = 0; k < 64; k++) begin : g_blk
    if (k < WINDOW_LEN) begin : g_data
      assign blk[k] = q_win_i[8*k +: 8];
    end else if (k == WINDOW_LEN) begin : g_pad
      assign blk[k] = 8'h80;
    end else if (k == 56) begin : g_len0
      assign blk[k] = 8'(MSG_BITS);
    end else if (k == 57) begin : g_len1
      assign blk[k] = 8'(MSG_BITS >> 8);
    end else begin : g_zero
      assign blk[k] = 8'h00;
    end
  end
  for (genvar w = 0; w < 16; w++) begin : g_word
    assign m0[32*w +: 32] = {blk[4*w+3], blk[4*w+2], blk[4*w+1], blk[4*w]};
  end

  // One round per stage
  for (genvar r = 0; r < 64; r++) begin : g_rnd
    localparam logic [3:0] G = md5_g(r);
    abcd_t        s_in;
    logic [511:0] m_in;
    meta_t        mt_in;
    logic         v_in;
    if (r == 0) begin : g_head
      assign s_in  = MD5_IV;
      assign m_in  = m0;
      assign mt_in = q_meta_i;
      assign v_in  = q_valid_i;
    end else begin : g_body
      assign s_in  = st_q[r-1];
      assign m_in  = m_q[r-1];
      assign mt_in = mt_q[r-1];
      assign v_in  = v_q[r-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[r] <= 1'b0;
      end else if (en) begin
        v_q[r] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[r] <= md5_round(s_in, m_in[32*G +: 32], MD5_K[r],
                             MD5_ROT[4*(r/16) + (r%4)], 2'(r/16));
        m_q[r]  <= m_in;
        mt_q[r] <= mt_in;
      end
    end
  end

  // Final add, compare and resolution against the found flag
  abcd_t       fin;
  meta_t       mt;
  logic        found_q, found_d, found_base;
  logic [31:0] cnt_q, cnt_d, cnt_base;
  logic        hashed, hit;

  assign fin.a = st_q[63].a + MD5_IV.a;
  assign fin.b = st_q[63].b + MD5_IV.b;
  assign fin.c = st_q[63].c + MD5_IV.c;
  assign fin.d = st_q[63].d + MD5_IV.d;
  assign mt    = mt_q[63];

  always_comb begin
    found_base = mt.first ? 1'b0 : found_q;
    cnt_base   = mt.first ? '0 : cnt_q;
    hashed     = mt.full && !found_base;
    hit        = hashed && ({fin.b, fin.a} == tgt_lo_i) && ({fin.d, fin.c} == tgt_hi_i);
    cnt_d      = (hashed && cnt_base != 32'hFFFF_FFFF) ? cnt_base + 32'd1 : cnt_base;
    found_d    = found_base || hit;
  end

  logic out_v_q;
  assign result_o.valid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (en) begin
      out_v_q <= v_q[63];
      if (v_q[63]) begin
        found_q <= found_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[63]) begin
      result_o.window_hashed  <= hashed;
      result_o.matched        <= hit;
      result_o.window_start   <= hashed ? mt.start : 32'd0;
      result_o.windows_hashed <= cnt_d;
    end
  end

endmodule

[tb/tb_md5_sliding_window_match_unit.sv]
// ----------------------------------------------------------------------------
// tb_md5_sliding_window_match_unit
// Self-checking bench for the MD5 sliding-window search unit.
// ----------------------------------------------------------------------------
// Text streams are driven through a valid/ready channel with random gaps.
// A local predictor keeps its own window, counters and MD5 and queues the
// expected result word for every accepted byte. The monitor stalls at random
// and checks each result word against the oldest expectation. Each phase
// programs a new target digest over APB while the unit is idle; most targets
// are taken from a window that the phase will actually send.
// ----------------------------------------------------------------------------
module tb_md5_sliding_window_match_unit;
  import md5sw_pkg::*;

  localparam int WIN       = 19;
  localparam int DRAIN     = 90;      // pipeline latency plus margin
  localparam int MAX_CYC   = 600000;
  localparam int NUM_ITEMS = 1950;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first;
  } text_word_t;

  typedef struct packed {
    logic        hashed;
    logic        matched;
    logic [31:0] start;
    logic [31:0] count;
  } result_word_t;

  // MD5 additive constants
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [63:0] pwdata, prdata;

  md5sw_in_if  text_if ();
  md5sw_out_if res_if ();

  md5_sliding_window_match_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Bench state
  text_word_t   send_q [$];
  result_word_t expect_q [$];
  logic [7:0]   win_bytes [WIN];
  int           fill_cnt;
  logic [31:0]  offset_cnt;
  logic [31:0]  hash_cnt;
  logic         found;
  logic [63:0]  tgt_lo, tgt_hi;
  int           errors, accepted, n_hashed, n_matched, cycles;
  int           gap_left, stall_left;
  logic         burst_mode;

  // Standard MD5 over one WIN-byte window; digest bytes 0..7 in lo
  function automatic void window_digest(input logic [7:0] w [WIN],
                                        output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0]  blk [64];
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < WIN; i++) blk[i] = w[i];
    blk[WIN] = 8'h80;
    blk[56]  = 8'(WIN * 8);
    blk[57]  = 8'((WIN * 8) >> 8);
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = f + a + SINE_K[i] + m[g];
      a = d;
      d = c;
      c = b;
      b = b + ((t << SHIFT_AMT[(i / 16) * 4 + i % 4]) |
               (t >> (32 - SHIFT_AMT[(i / 16) * 4 + i % 4])));
    end
    a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
    lo = {b, a};
    hi = {d, c};
  endfunction

  // Advance the search state by one byte and return the expected word
  function automatic result_word_t search_step(input text_word_t wd);
    result_word_t r;
    logic [31:0]  here;
    logic [63:0]  lo, hi;
    r = '0;
    if (wd.first) begin
      for (int i = 0; i < WIN; i++) win_bytes[i] = 8'h00;
      fill_cnt = 0; offset_cnt = '0; hash_cnt = '0; found = 1'b0;
    end
    here = offset_cnt;
    for (int i = 0; i < WIN - 1; i++) win_bytes[i] = win_bytes[i+1];
    win_bytes[WIN-1] = wd.text_byte;
    if (fill_cnt < WIN) fill_cnt++;
    offset_cnt = here + 32'd1;
    if (fill_cnt >= WIN && !found) begin
      window_digest(win_bytes, lo, hi);
      if (hash_cnt != 32'hFFFF_FFFF) hash_cnt++;
      r.hashed = 1'b1;
      r.start  = here - 32'(WIN - 1);
      if (lo == tgt_lo && hi == tgt_hi) begin
        r.matched = 1'b1;
        found     = 1'b1;
      end
    end
    r.count = hash_cnt;
    return r;
  endfunction

  function automatic int draw_wait();
    if (burst_mode) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
  endfunction

  // Text driver: predicts on acceptance, then presents the next word
  always @(posedge clk_i or negedge rst_ni) begin
    text_word_t   nxt;
    result_word_t er;
    logic         busy;
    if (!rst_ni) begin
      text_if.valid           <= 1'b0;
      text_if.text_byte       <= 8'h00;
      text_if.first_of_stream <= 1'b0;
      gap_left                = 0;
    end else begin
      busy = text_if.valid;
      if (text_if.valid && text_if.ready) begin
        er = search_step('{text_byte: text_if.text_byte, first: text_if.first_of_stream});
        expect_q.push_back(er);
        accepted++;
        busy = 1'b0;
        gap_left = draw_wait();
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          text_if.valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          nxt = send_q.pop_front();
          text_if.valid           <= 1'b1;
          text_if.text_byte       <= nxt.text_byte;
          text_if.first_of_stream <= nxt.first;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t got, want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{hashed: res_if.window_hashed, matched: res_if.matched,
                start: res_if.window_start, count: res_if.windows_hashed};
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result word %h", got);
        end else begin
          want = expect_q.pop_front();
          if (got.hashed) n_hashed++;
          if (got.matched) n_matched++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: hashed %b/%b matched %b/%b start %h/%h count %h/%h (exp/act)",
                       want.hashed, got.hashed, want.matched, got.matched,
                       want.start, got.start, want.count, got.count);
          end
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("** md5_sliding_window_match_unit: FAILED **");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (send_q.size() != 0 || text_if.valid || expect_q.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [63:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TGT_LO) tgt_lo = val;
    else tgt_hi = val;
  endtask

  task automatic set_target(input logic [63:0] lo, input logic [63:0] hi);
    wait_idle();
    apb_write(REG_TGT_LO, lo);
    apb_write(REG_TGT_HI, hi);
  endtask

  // Build one random stream into words; style picks the byte pattern
  task automatic build_stream(ref text_word_t words [$], input int len, input logic fresh);
    int          style;
    logic [7:0]  v;
    style = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      case (style)
        0:       v = 8'hA5;
        1:       v = (i % 2) ? 8'hFF : 8'h00;
        2:       v = 8'($urandom_range(0, 3));
        default: v = 8'($urandom);
      endcase
      words.push_back('{text_byte: v, first: (i == 0) && fresh});
    end
  endtask

  initial begin
    text_word_t  words [$];
    logic [7:0]  w [WIN];
    logic [63:0] lo, hi;
    int          total, len, src_start, src_len, k, phase;

    clk_i = 1'b0; rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    text_if.valid = 1'b0; text_if.text_byte = '0; text_if.first_of_stream = 1'b0;
    res_if.ready = 1'b0;
    tgt_lo = '0; tgt_hi = '0;
    fill_cnt = 0; offset_cnt = '0; hash_cnt = '0; found = 1'b0;
    for (int i = 0; i < WIN; i++) win_bytes[i] = 8'h00;
    errors = 0; accepted = 0; n_hashed = 0; n_matched = 0; cycles = 0;
    burst_mode = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: match on the very last byte of an all-ones window, then
    // bytes after the match, then a stream too short to fill the window
    for (int i = 0; i < WIN; i++) w[i] = 8'hFF;
    window_digest(w, lo, hi);
    set_target(lo, hi);
    for (int i = 0; i < WIN; i++) send_q.push_back('{text_byte: 8'hFF, first: i == 0});
    send_q.push_back('{text_byte: 8'h00, first: 1'b0});
    send_q.push_back('{text_byte: 8'h7F, first: 1'b0});
    send_q.push_back('{text_byte: 8'h00, first: 1'b1});
    send_q.push_back('{text_byte: 8'h80, first: 1'b0});
    total = 23;

    // Extreme targets: all ones, then all zeros
    set_target('1, '1);
    words.delete();
    build_stream(words, 30, 1'b1);
    foreach (words[i]) send_q.push_back(words[i]);
    total += 30;
    set_target('0, '0);

    // Random phases: most aim the target at a window the phase will send
    phase = 0;
    while (total < NUM_ITEMS) begin
      words.delete();
      src_start = -1;
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(0, 9))
          0, 1:    len = $urandom_range(1, WIN - 1);
          2:       len = $urandom_range(80, 160);
          default: len = $urandom_range(WIN, 60);
        endcase
        if (src_start < 0 && len >= WIN) begin
          src_start = words.size();
          src_len   = len;
        end
        build_stream(words, len, s == 0 || $urandom_range(0, 7) != 0);
      end
      if (src_start >= 0 && $urandom_range(0, 4) != 0) begin
        k = src_start + $urandom_range(WIN - 1, src_len - 1);
        for (int i = 0; i < WIN; i++) w[i] = words[k - (WIN - 1) + i].text_byte;
        window_digest(w, lo, hi);
        set_target(lo, hi);
      end else begin
        set_target({$urandom, $urandom}, {$urandom, $urandom});
      end
      burst_mode = (phase % 5 == 2);
      foreach (words[i]) send_q.push_back(words[i]);
      total += words.size();
      phase++;
    end

    wait_idle();
    $display("Sent %0d bytes in %0d random phases; %0d windows hashed, %0d matches.",
             accepted, phase, n_hashed, n_matched);
    if (errors == 0) begin
      $display("** md5_sliding_window_match_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** md5_sliding_window_match_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
design/md5sw_pkg.sv
design/md5sw_if.sv
design/md5sw_front.sv
design/md5sw_queue.sv
design/md5sw_back.sv
design/md5_sliding_window_match_unit.sv
tb/tb_md5_sliding_window_match_unit.sv
